// ===== hdl/lrs_pkg.sv =====
// Package for the LRU recency stack: widths, action codes and the structs
// passed along the cell chain. No dependencies.
package lrs_pkg;

    localparam int FRAME_W        = 6;
    localparam int CFG_W          = 7;
    localparam int MAX_FRAMES_DEF = 64;
    localparam int S_TDATA_W      = 8;
    localparam int M_TDATA_W      = 8;
    localparam int M_TUSER_W      = 2;

    localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(64);

    localparam logic ACT_REFERENCE = 1'b0;
    localparam logic ACT_EVICT     = 1'b1;

    // Broadcast to every cell for the beat being accepted.
    typedef struct packed {
        logic               evict;
        logic [FRAME_W-1:0] frame;
        logic               found;
        logic               full;
    } lrs_cmd_t;

    // Contents of one cell, handed to the next deeper cell.
    typedef struct packed {
        logic               valid;
        logic [FRAME_W-1:0] entry;
    } lrs_slot_t;

    // Summary of the deeper part of the chain, rippling toward the top.
    typedef struct packed {
        logic               valid;
        logic               hit;
        logic               full;
        logic [FRAME_W-1:0] tail;
    } lrs_link_t;

endpackage

// ===== hdl/lrs_cell.sv =====
// One position of the recency stack: holds an entry and its valid bit.
// Depends on lrs_pkg.
module lrs_cell #(
    parameter int IDX_W = 6,
    parameter int IDX   = 0
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              go,
    input  lrs_pkg::lrs_cmd_t cmd,
    input  logic [IDX_W-1:0]  cap_m1,
    input  lrs_pkg::lrs_slot_t slot_in,
    output lrs_pkg::lrs_slot_t slot_out,
    input  lrs_pkg::lrs_link_t up_in,
    output lrs_pkg::lrs_link_t up_out
);
    import lrs_pkg::*;

    logic               valid_reg, valid_next;
    logic [FRAME_W-1:0] entry_reg, entry_next;
    logic               match;
    logic               is_tail;

    assign match   = valid_reg && (entry_reg == cmd.frame);
    assign is_tail = valid_reg && !up_in.valid;

    always_comb begin
        up_out.valid = valid_reg;
        up_out.hit   = match || up_in.hit;
        up_out.full  = (valid_reg && (cap_m1 == IDX_W'(IDX))) || up_in.full;
        up_out.tail  = is_tail ? entry_reg : up_in.tail;
    end

    assign slot_out.valid = valid_reg;
    assign slot_out.entry = entry_reg;

    always_comb begin
        valid_next = valid_reg;
        entry_next = entry_reg;
        if (cmd.evict) begin
            if (is_tail) begin
                valid_next = 1'b0;
            end
        end else if (cmd.found) begin
            if (up_out.hit) begin
                entry_next = slot_in.entry;
            end
        end else if (cmd.full) begin
            if (valid_reg) begin
                entry_next = slot_in.entry;
            end
        end else if (valid_reg || slot_in.valid) begin
            entry_next = slot_in.entry;
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (go) begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (go) begin
            entry_reg <= entry_next;
        end
    end

endmodule

// ===== hdl/lru_recency_stack_top.sv =====
// Top level of the LRU recency stack: capacity register, cell chain and
// output register. Depends on lrs_pkg and lrs_cell.
//
// Takes one beat per clock while s_tready is high and returns exactly one
// result beat for each from the output register; s_tready is high whenever
// the output register is empty or being drained. The stack is a row of
// MAX_FRAMES cells that all compare the frame at once; the match, fill and
// tail summaries ripple from the deepest cell to the top within the cycle,
// so that chain sets the clock period. Reset clears the stack and sets the
// capacity to 64. Capacity 0 acts as 1, values above MAX_FRAMES act as MAX_FRAMES.
module lru_recency_stack_top #(
    parameter int MAX_FRAMES = lrs_pkg::MAX_FRAMES_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [lrs_pkg::CFG_W-1:0]       cfg_data,     // frames_in_use
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [lrs_pkg::S_TDATA_W-1:0]   s_tdata,      // [5:0] frame_number
    input  logic                            s_tuser,      // action
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [lrs_pkg::M_TDATA_W-1:0]   m_tdata,      // [5:0] victim_frame
    output logic [lrs_pkg::M_TUSER_W-1:0]   m_tuser       // [0] victim_valid, [1] was_present
);
    import lrs_pkg::*;

    localparam int IDX_W = $clog2(MAX_FRAMES);
    localparam int CNT_W = $clog2(MAX_FRAMES + 1);
    localparam int CW    = (CNT_W > CFG_W) ? CNT_W : CFG_W;

    logic [CFG_W-1:0]     cap_cfg_reg;
    logic [CW-1:0]        cfg_ext, cap_lo, cap;
    logic [IDX_W-1:0]     cap_m1;

    logic                 s_fire;
    lrs_cmd_t             cmd;
    lrs_slot_t            head_slot;
    lrs_slot_t            slot_w [MAX_FRAMES];
    lrs_link_t            up_w   [MAX_FRAMES+1];
    logic [MAX_FRAMES-1:0] valid_vec;

    logic                 victim_valid, was_present;
    logic [FRAME_W-1:0]   victim_frame;

    logic                 m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic [M_TUSER_W-1:0] m_tuser_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_cfg_reg <= CFG_RESET;
        end else if (cfg_valid) begin
            cap_cfg_reg <= cfg_data;
        end
    end

    always_comb begin
        cfg_ext = CW'(cap_cfg_reg);
        cap_lo  = (cfg_ext == '0) ? CW'(1) : cfg_ext;
        cap     = (cap_lo > CW'(MAX_FRAMES)) ? CW'(MAX_FRAMES) : cap_lo;
        cap_m1  = IDX_W'(cap - CW'(1));
    end

    assign s_tready = !m_tvalid_reg || m_tready;
    assign s_fire   = s_tvalid && s_tready;

    assign up_w[MAX_FRAMES] = '0;

    always_comb begin
        cmd.evict = (s_tuser == ACT_EVICT);
        cmd.frame = s_tdata[FRAME_W-1:0];
        cmd.found = up_w[0].hit;
        cmd.full  = up_w[0].full;
        head_slot.valid = 1'b1;
        head_slot.entry = s_tdata[FRAME_W-1:0];
    end

    for (genvar i = 0; i < MAX_FRAMES; i++) begin : g_cell
        lrs_slot_t cell_in;
        if (i == 0) begin : g_head
            assign cell_in = head_slot;
        end else begin : g_body
            assign cell_in = slot_w[i-1];
        end

        lrs_cell #(
            .IDX_W (IDX_W),
            .IDX   (i)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .go       (s_fire),
            .cmd      (cmd),
            .cap_m1   (cap_m1),
            .slot_in  (cell_in),
            .slot_out (slot_w[i]),
            .up_in    (up_w[i+1]),
            .up_out   (up_w[i])
        );

        assign valid_vec[i] = slot_w[i].valid;
    end

    always_comb begin
        if (cmd.evict) begin
            victim_valid = up_w[0].valid;
            was_present  = 1'b0;
        end else begin
            victim_valid = !cmd.found && cmd.full;
            was_present  = cmd.found;
        end
        victim_frame = victim_valid ? up_w[0].tail : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (s_fire) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            m_tdata_reg <= M_TDATA_W'(victim_frame);
            m_tuser_reg <= {was_present, victim_valid};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // stack stays packed toward the top
    a_packed: assert property (@(posedge aclk) disable iff (!aresetn)
        ((valid_vec >> 1) & ~valid_vec) == '0)
        else $error("recency stack has a hole");

    a_flags_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
        else $error("victim reported on a hit");

    a_empty_evict: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && s_tuser == ACT_EVICT && !valid_vec[0]) |=> !m_tuser[0])
        else $error("victim reported from empty stack");

    a_evict_shrinks: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && s_tuser == ACT_EVICT) |=>
            ($countones(valid_vec) + 1 == $countones($past(valid_vec))) ||
            ($past(valid_vec) == '0))
        else $error("eviction did not drop one entry");

endmodule

// ===== verif/tb_lru_recency_stack_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for lru_recency_stack_top: directed and random frame references
// and evictions under several capacities, idle patterns and a long output hold-off.
// Depends on lrs_pkg and the RTL under hdl/.
module tb_lru_recency_stack_top;
    import lrs_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_CYCLES = 60;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

    typedef struct packed {
        logic [FRAME_W-1:0] victim_frame;
        logic               victim_valid;
        logic               was_present;
    } victim_t;

    class recency_scoreboard;
        logic [FRAME_W-1:0] recency_q[$];     // [0] is most recent
        logic [CFG_W-1:0]   frames_in_use;
        victim_t            expected_q[$];
        int                 errors;

        function new();
            frames_in_use = CFG_RESET;
            errors        = 0;
        endfunction

        function void set_frames_in_use(logic [CFG_W-1:0] value);
            frames_in_use = value;
        endfunction

        function int capacity();
            int c;
            c = frames_in_use;
            if (c == 0) c = 1;
            if (c > MAX_FRAMES_DEF) c = MAX_FRAMES_DEF;
            return c;
        endfunction

        function void apply_access(logic action, logic [FRAME_W-1:0] frame);
            victim_t r;
            int      hit_at;
            r      = '0;
            hit_at = -1;
            if (action == ACT_EVICT) begin
                if (recency_q.size() > 0) begin
                    r.victim_frame = recency_q.pop_back();
                    r.victim_valid = 1'b1;
                end
            end else begin
                for (int i = 0; i < recency_q.size(); i++) begin
                    if (recency_q[i] == frame) begin
                        hit_at = i;
                        break;
                    end
                end
                if (hit_at >= 0) begin
                    r.was_present = 1'b1;
                    recency_q.delete(hit_at);
                end else if (recency_q.size() >= capacity()) begin
                    r.victim_frame = recency_q.pop_back();
                    r.victim_valid = 1'b1;
                end
                recency_q.push_front(frame);
            end
            expected_q.push_back(r);
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                errors++;
                $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
            end
        endfunction

        function void check_victim(victim_t got);
            victim_t want;
            if (expected_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result beat: expected none, actual %0d/%0b/%0b",
                         $time, got.victim_frame, got.victim_valid, got.was_present);
                return;
            end
            want = expected_q.pop_front();
            compare_field("victim_frame", want.victim_frame, got.victim_frame);
            compare_field("victim_valid", want.victim_valid, got.victim_valid);
            compare_field("was_present", want.was_present, got.was_present);
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_W-1:0]     cfg_data;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;

    recency_scoreboard sb = new();
    idle_mode_t        idle_mode = IDLE_NONE;
    int                pressure_req = 0;
    int                stall_cycles;

    lru_recency_stack_top i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) begin
            sb.apply_access(s_tuser, s_tdata[FRAME_W-1:0]);
        end
        if (aresetn && m_tvalid && m_tready) begin
            sb.check_victim({m_tdata[FRAME_W-1:0], m_tuser[0], m_tuser[1]});
        end
    end

    initial begin
        stall_cycles = 0;
        forever begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
            end
            if (stall_cycles >= STALL_LIMIT) begin
                $display("** lru_recency_stack_top: FAILED **");
                $finish;
            end
        end
    end

    // Result side: random stalls per idle mode, plus one long hold-off on request.
    initial begin
        int hold_left;
        hold_left = 0;
        m_tready <= 1'b1;
        forever begin
            @(posedge aclk);
            if (pressure_req != 0) begin
                pressure_req = 0;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                case (idle_mode)
                    IDLE_RECEIVER: m_tready <= ($urandom_range(0, 99) >= 70);
                    IDLE_BOTH:     m_tready <= ($urandom_range(0, 99) >= 14);
                    default:       m_tready <= 1'b1;
                endcase
            end
        end
    end

    function automatic bit sender_idles();
        case (idle_mode)
            IDLE_SENDER: return $urandom_range(0, 99) < 70;
            IDLE_BOTH:   return $urandom_range(0, 99) < 14;
            default:     return 1'b0;
        endcase
    endfunction

    task automatic send_beat(logic action, logic [FRAME_W-1:0] frame);
        while (sender_idles()) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= action;
        s_tdata  <= S_TDATA_W'(frame);
        do @(posedge aclk); while (!s_tready);
    endtask

    // Stop sending and wait for every outstanding result, then the output latency.
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_frames_in_use(logic [CFG_W-1:0] value);
        settle();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.set_frames_in_use(value);
    endtask

    task automatic run_phase(logic [CFG_W-1:0] cap, idle_mode_t mode, int items, bit squeeze);
        int                 pool_top;
        logic               action;
        logic [FRAME_W-1:0] frame;
        write_frames_in_use(cap);
        idle_mode = mode;
        if (squeeze) pressure_req = 1;
        // draw mostly from a pool a bit larger than the capacity so hits and drops both occur
        pool_top = sb.capacity() + sb.capacity() / 2 + 1;
        if (pool_top > 63) pool_top = 63;
        for (int k = 0; k < items; k++) begin
            action = ($urandom_range(0, 99) < 15) ? ACT_EVICT : ACT_REFERENCE;
            frame  = ($urandom_range(0, 4) == 0) ? FRAME_W'($urandom_range(0, 63))
                                                 : FRAME_W'($urandom_range(0, pool_top));
            send_beat(action, frame);
        end
    endtask

    initial begin
        aresetn   <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= ACT_REFERENCE;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed, reset capacity
        send_beat(ACT_EVICT, 6'd0);          // empty stack
        send_beat(ACT_REFERENCE, 6'd0);
        send_beat(ACT_EVICT, 6'd0);          // single entry removed
        send_beat(ACT_EVICT, 6'd63);
        send_beat(ACT_REFERENCE, 6'd63);
        send_beat(ACT_REFERENCE, 6'd63);     // already most recent
        send_beat(ACT_REFERENCE, 6'd42);
        send_beat(ACT_REFERENCE, 6'd21);
        send_beat(ACT_REFERENCE, 6'd63);     // hit below the top
        send_beat(ACT_REFERENCE, 6'd0);
        send_beat(ACT_EVICT, 6'd63);
        send_beat(ACT_REFERENCE, 6'd42);

        run_phase(7'd0,   IDLE_NONE,     40,  1'b0);   // zero acts as one
        run_phase(7'd2,   IDLE_SENDER,   60,  1'b0);
        run_phase(7'd127, IDLE_RECEIVER, 110, 1'b0);   // clamped to the stack depth
        run_phase(7'd3,   IDLE_BOTH,     100, 1'b0);   // below the current count
        run_phase(7'd8,   IDLE_NONE,     120, 1'b1);
        run_phase(7'd1,   IDLE_SENDER,   60,  1'b0);
        run_phase(7'd16,  IDLE_RECEIVER, 120, 1'b0);
        run_phase(7'd64,  IDLE_BOTH,     120, 1'b0);
        run_phase(7'd5,   IDLE_NONE,     60,  1'b0);
        settle();

        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("** lru_recency_stack_top: PASSED **");
        end else begin
            $display("** lru_recency_stack_top: FAILED **");
        end
        $finish;
    end

endmodule
